// ===== hw/rtl/cht_pkg.sv =====
// Shared types, constants and codes for the chained hash table.
`timescale 1ns / 1ps
package cht_pkg;

    localparam int NUM_BUCKETS  = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int CFG_W        = 7;
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int NODE_W       = $clog2(POOL_ENTRIES + 1);
    localparam logic [NODE_W-1:0] NODE_NIL = NODE_W'(POOL_ENTRIES);
    localparam logic [CFG_W-1:0]  BUCKETS_RESET = CFG_W'(NUM_BUCKETS);

    // Remainder unit: one hex digit of the key per step.
    localparam int DIGIT_W    = 4;
    localparam int HASH_STEPS = KEY_W / DIGIT_W;
    localparam int STEP_W     = $clog2(HASH_STEPS);
    localparam int MULT_W     = CFG_W + DIGIT_W;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_ALLOC_RD,
        S_ALLOC_WAIT,
        S_NEW_WR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK_RD,
        S_WALK_WAIT,
        S_UNLINK,
        S_FREE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  payload;
        logic [NODE_W-1:0] link;
    } node_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        node_t            wdata;
        logic [IDX_W-1:0] raddr;
    } node_req_t;

    typedef struct packed {
        logic              we;
        logic [BKT_W-1:0]  waddr;
        logic [NODE_W-1:0] wdata;
        logic [BKT_W-1:0]  raddr;
    } head_req_t;

endpackage

// ===== hw/rtl/cht_if.sv =====
// Channel interfaces: command, response and configuration write.
`timescale 1ns / 1ps
interface cht_cmd_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [cht_pkg::KEY_W-1:0] key;
    logic [cht_pkg::VAL_W-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface cht_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [cht_pkg::VAL_W-1:0] found_value;

    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

interface cht_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cht_pkg::CFG_W-1:0] bucket_count;

    modport source (output valid, bucket_count, input ready);
    modport sink   (input valid, bucket_count, output ready);
endinterface

// ===== hw/rtl/cht_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/cht_hash.sv =====
// Bucket index unit: key modulo the bucket count, one hex digit per cycle.
`timescale 1ns / 1ps
module cht_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cht_pkg::KEY_W-1:0] key,
    input  logic [cht_pkg::CFG_W-1:0] bucket_count,
    output logic                      done,
    output logic [cht_pkg::BKT_W-1:0] bucket
);
    import cht_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [KEY_W-1:0]    shift_reg, shift_next;
    logic [BKT_W-1:0]    rem_reg, rem_next;
    logic [CFG_W-1:0]    divisor;
    logic [MULT_W-1:0]   partial;
    logic [MULT_W-1:0]   sub;

    // A zero count acts as one; a count above the table size saturates.
    always_comb
    begin
        if (bucket_count == '0)
            divisor = CFG_W'(1);
        else if (bucket_count > BUCKETS_RESET)
            divisor = BUCKETS_RESET;
        else
            divisor = bucket_count;
    end

    // One radix-16 remainder step: pick the largest multiple that fits.
    always_comb
    begin
        partial = MULT_W'({rem_reg, shift_reg[KEY_W-1 -: DIGIT_W]});
        sub     = '0;
        for (int q = 1; q < (1 << DIGIT_W); q++)
        begin
            if (partial >= MULT_W'(divisor) * MULT_W'(q))
                sub = MULT_W'(divisor) * MULT_W'(q);
        end
        rem_next = BKT_W'(partial - sub);
    end

    // Step sequencing.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            shift_next = key;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << DIGIT_W;
            step_next  = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(HASH_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (start)
            rem_reg <= '0;
        else if (busy_reg)
            rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

    // The finished remainder always lies below the divisor.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (CFG_W'(rem_reg) < divisor))
        else $error("bucket index not below bucket count");

endmodule

// ===== hw/rtl/cht_ctrl.sv =====
// Command sequencer: allocation, chain walk, unlink and response register.
`timescale 1ns / 1ps
module cht_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    cht_cmd_if.sink                    cmd,
    cht_rsp_if.source                  rsp,
    output logic                       hash_start,
    input  logic                       hash_done,
    input  logic [cht_pkg::BKT_W-1:0]  hash_bucket,
    output cht_pkg::node_req_t         node_req,
    input  cht_pkg::node_t             node_rdata,
    output cht_pkg::head_req_t         head_req,
    input  logic [cht_pkg::NODE_W-1:0] head_rdata
);
    import cht_pkg::*;

    state_t            state_reg, state_next;
    cmd_t              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    logic [NODE_W-1:0] new_reg, new_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] prev_reg, prev_next;
    node_t             cur_word_reg, cur_word_next;
    node_t             prev_word_reg, prev_word_next;
    logic [NODE_W-1:0] free_head_reg, free_head_next;
    logic [NODE_W-1:0] fresh_reg, fresh_next;
    logic [NUM_BUCKETS-1:0] head_valid_reg, head_valid_next;
    status_t           sts_reg, sts_next;
    logic [VAL_W-1:0]  found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_sts_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              in_fire;
    logic              known_cmd;
    logic              out_load;
    logic [NODE_W-1:0] head_node;
    logic              key_match;

    assign in_fire   = cmd.valid && cmd.ready;
    assign known_cmd = (cmd.command == CMD_ADD) || (cmd.command == CMD_GET)
                       || (cmd.command == CMD_REMOVE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign head_node = head_valid_reg[bkt_reg] ? head_rdata : NODE_NIL;
    assign key_match = (node_rdata.key == key_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                    state_next = known_cmd ? S_HASH : S_DONE;
            end
            S_HASH:
            begin
                if (hash_done)
                    state_next = (op_reg == CMD_ADD) ? S_ALLOC_RD : S_HEAD_RD;
            end
            S_ALLOC_RD:
            begin
                if (free_head_reg != NODE_NIL)
                    state_next = S_ALLOC_WAIT;
                else if (fresh_reg != NODE_NIL)
                    state_next = S_NEW_WR;
                else
                    state_next = S_DONE;
            end
            S_ALLOC_WAIT: state_next = S_NEW_WR;
            S_NEW_WR:     state_next = S_HEAD_RD;
            S_HEAD_RD:    state_next = S_HEAD_WAIT;
            S_HEAD_WAIT:
            begin
                state_next = (head_node == NODE_NIL) ? S_DONE : S_WALK_RD;
            end
            S_WALK_RD:    state_next = S_WALK_WAIT;
            S_WALK_WAIT:
            begin
                if (op_reg == CMD_ADD)
                    state_next = (node_rdata.link == NODE_NIL) ? S_DONE : S_WALK_RD;
                else if (key_match)
                    state_next = (op_reg == CMD_REMOVE) ? S_UNLINK : S_DONE;
                else
                    state_next = (node_rdata.link == NODE_NIL) ? S_DONE : S_WALK_RD;
            end
            S_UNLINK:     state_next = S_FREE;
            S_FREE:       state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Outputs, memory requests and datapath updates.
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        bkt_next        = bkt_reg;
        new_next        = new_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        cur_word_next   = cur_word_reg;
        prev_word_next  = prev_word_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        head_valid_next = head_valid_reg;
        sts_next        = sts_reg;
        found_next      = found_reg;
        hash_start      = 1'b0;
        cmd.ready       = (state_reg == S_IDLE);
        node_req        = '0;
        head_req        = '0;
        node_req.raddr  = cur_reg[IDX_W-1:0];
        head_req.raddr  = bkt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = cmd_t'(cmd.command);
                    key_next   = cmd.key;
                    value_next = cmd.value;
                    sts_next   = STS_NOT_FOUND;
                    found_next = '0;
                    hash_start = known_cmd;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                    bkt_next = hash_bucket;
            end
            S_ALLOC_RD:
            begin
                node_req.raddr = free_head_reg[IDX_W-1:0];
                if (free_head_reg == NODE_NIL)
                begin
                    if (fresh_reg != NODE_NIL)
                    begin
                        new_next   = fresh_reg;
                        fresh_next = fresh_reg + NODE_W'(1);
                    end
                    else
                    begin
                        sts_next = STS_FULL;
                    end
                end
            end
            S_ALLOC_WAIT:
            begin
                new_next       = free_head_reg;
                free_head_next = node_rdata.link;
            end
            S_NEW_WR:
            begin
                node_req.we            = 1'b1;
                node_req.waddr         = new_reg[IDX_W-1:0];
                node_req.wdata.key     = key_reg;
                node_req.wdata.payload = value_reg;
                node_req.wdata.link    = NODE_NIL;
            end
            S_HEAD_WAIT:
            begin
                cur_next  = head_node;
                prev_next = NODE_NIL;
                if (head_node == NODE_NIL && op_reg == CMD_ADD)
                begin
                    head_req.we              = 1'b1;
                    head_req.waddr           = bkt_reg;
                    head_req.wdata           = new_reg;
                    head_valid_next[bkt_reg] = 1'b1;
                    sts_next                 = STS_OK;
                end
            end
            S_WALK_WAIT:
            begin
                cur_word_next = node_rdata;
                if (op_reg == CMD_ADD)
                begin
                    // Append the new node behind the current tail.
                    if (node_rdata.link == NODE_NIL)
                    begin
                        node_req.we         = 1'b1;
                        node_req.waddr      = cur_reg[IDX_W-1:0];
                        node_req.wdata      = node_rdata;
                        node_req.wdata.link = new_reg;
                        sts_next            = STS_OK;
                    end
                    else
                    begin
                        cur_next = node_rdata.link;
                    end
                end
                else if (key_match)
                begin
                    if (op_reg == CMD_GET)
                    begin
                        sts_next   = STS_OK;
                        found_next = node_rdata.payload;
                    end
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_word_next = node_rdata;
                    cur_next       = node_rdata.link;
                end
            end
            S_UNLINK:
            begin
                // Bypass the matching node from its predecessor or the head.
                if (prev_reg != NODE_NIL)
                begin
                    node_req.we         = 1'b1;
                    node_req.waddr      = prev_reg[IDX_W-1:0];
                    node_req.wdata      = prev_word_reg;
                    node_req.wdata.link = cur_word_reg.link;
                end
                else
                begin
                    head_req.we    = 1'b1;
                    head_req.waddr = bkt_reg;
                    head_req.wdata = cur_word_reg.link;
                end
            end
            S_FREE:
            begin
                // Push the released node onto the free list.
                node_req.we         = 1'b1;
                node_req.waddr      = cur_reg[IDX_W-1:0];
                node_req.wdata      = cur_word_reg;
                node_req.wdata.link = free_head_reg;
                free_head_next      = cur_reg;
                sts_next            = STS_OK;
            end
            default:
            begin
            end
        endcase
    end

    // Response register; a new command may be taken while it is occupied.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_sts_reg;
    assign rsp.found_value = out_value_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= NODE_NIL;
            fresh_reg      <= '0;
            head_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            fresh_reg      <= fresh_next;
            head_valid_reg <= head_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        bkt_reg       <= bkt_next;
        new_reg       <= new_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        cur_word_reg  <= cur_word_next;
        prev_word_reg <= prev_word_next;
        sts_reg       <= sts_next;
        found_reg     <= found_next;
        if (out_load)
        begin
            out_sts_reg   <= sts_reg;
            out_value_reg <= found_reg;
        end
    end

    // The free list only holds nodes that were once allocated.
    a_free_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NODE_NIL) || (free_head_reg < fresh_reg))
        else $error("free list points at a never-allocated node");

    // The fresh counter never passes the pool size.
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NODE_NIL)
        else $error("fresh node counter overflow");

    // One command at a time: no second accept right after a transaction.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !cmd.ready)
        else $error("command accepted while busy");

endmodule

// ===== hw/rtl/chained_hash_table_top.sv =====
// Top level of the chained hash table: config register, memories, sequencer.
//
//  channel  dir  payload                          transaction
//  cmd      in   command, key, value              valid & ready
//  rsp      out  status, found_value              valid & ready
//  cfg      in   bucket_count                     valid & ready (always ready)
//
// A known command is hashed first: the remainder unit takes one key digit a
// cycle and then hands the bucket over; the unused command skips hashing.
// A lookup or remove then reads the bucket head and walks its chain node by
// node through the node memory's read port; remove adds an unlink write and a
// free write, add allocates and writes the new node before linking it in.
// Reset clears the bucket valid bits at once; no clearing pass is needed.
// A waiting response does not stall the next command's acceptance, only the loading of its result.
`timescale 1ns / 1ps
module chained_hash_table_top (
    input  logic      clk,
    input  logic      rst_n,
    cht_cmd_if.sink   cmd,
    cht_rsp_if.source rsp,
    cht_cfg_if.sink   cfg
);
    import cht_pkg::*;

    logic [CFG_W-1:0]  bucket_count_reg;
    logic              hash_start;
    logic              hash_done;
    logic [BKT_W-1:0]  hash_bucket;
    node_req_t         node_req;
    node_t             node_rdata;
    head_req_t         head_req;
    logic [NODE_W-1:0] head_rdata;

    // Bucket count register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_count_reg <= BUCKETS_RESET;
        else if (cfg.valid)
            bucket_count_reg <= cfg.bucket_count;
    end

    // Remainder unit.
    cht_hash u_hash (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (hash_start),
        .key          (cmd.key),
        .bucket_count (bucket_count_reg),
        .done         (hash_done),
        .bucket       (hash_bucket)
    );

    // Node memory: key, payload and link of each pool entry.
    cht_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (POOL_ENTRIES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_req.we),
        .waddr (node_req.waddr),
        .wdata (node_req.wdata),
        .raddr (node_req.raddr),
        .rdata (node_rdata)
    );

    // Bucket head memory.
    cht_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NUM_BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_req.we),
        .waddr (head_req.waddr),
        .wdata (head_req.wdata),
        .raddr (head_req.raddr),
        .rdata (head_rdata)
    );

    // Command sequencer.
    cht_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .hash_start  (hash_start),
        .hash_done   (hash_done),
        .hash_bucket (hash_bucket),
        .node_req    (node_req),
        .node_rdata  (node_rdata),
        .head_req    (head_req),
        .head_rdata  (head_rdata)
    );

endmodule
